// ----- hw/rtl/fcne_pkg.sv -----
package fcne_pkg;

   // Coordinate and arithmetic widths
   localparam int COORD_WIDTH = 16;
   localparam int UPLEN_W     = 33;
   localparam int DIFF_W      = COORD_WIDTH + 1;
   localparam int SQ_W        = 2 * DIFF_W;
   localparam int CROSS_W     = 2 * DIFF_W + 1;
   localparam int DIST_W      = 2 * COORD_WIDTH + 1;
   localparam int CMP_W       = (DIST_W > UPLEN_W) ? DIST_W : UPLEN_W;

   // Stream packing
   localparam int REQ_COORDS  = 6;
   localparam int RSP_COORDS  = 4;
   localparam int REQ_DATA_W  = ((REQ_COORDS * COORD_WIDTH + 7) / 8) * 8;
   localparam int RSP_DATA_W  = ((RSP_COORDS * COORD_WIDTH + 7) / 8) * 8;
   localparam int REQ_USER_W  = 2;
   localparam int USER_HAS_POINT = 0;
   localparam int USER_FIRST     = 1;

   // Register file
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = UPLEN_W;
   localparam logic [CSR_INDEX_W-1:0] CSR_UPPER_LENGTH = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_SUCC_MODE    = CSR_INDEX_W'(1);

   typedef logic signed [COORD_WIDTH-1:0] coord_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
   } point_type;

   typedef struct packed {
      point_type tail;
      point_type head;
   } edge_type;

   typedef struct packed {
      edge_type  query;
      point_type pt;
      logic      has_point;
      logic      first;
      logic      last;
   } item_type;

   typedef struct packed {
      edge_type  query;
      point_type pt;
      logic      cand;
      logic      pt_left_edge;
      logic      first;
      logic      last;
   } cand_type;

   typedef struct packed {
      point_type tail;
      point_type head;
      logic      found;
   } result_type;

   // Strict left turn: (b - a) x (c - a) > 0
   function automatic logic is_left(point_type a, point_type b, point_type c);
      logic signed [DIFF_W-1:0]  ux;
      logic signed [DIFF_W-1:0]  uy;
      logic signed [DIFF_W-1:0]  vx;
      logic signed [DIFF_W-1:0]  vy;
      logic signed [CROSS_W-1:0] cr;
      ux = DIFF_W'($signed(b.x)) - DIFF_W'($signed(a.x));
      uy = DIFF_W'($signed(b.y)) - DIFF_W'($signed(a.y));
      vx = DIFF_W'($signed(c.x)) - DIFF_W'($signed(a.x));
      vy = DIFF_W'($signed(c.y)) - DIFF_W'($signed(a.y));
      cr = CROSS_W'(ux) * CROSS_W'(vy) - CROSS_W'(uy) * CROSS_W'(vx);
      return !cr[CROSS_W-1] && (cr != '0);
   endfunction

endpackage

// ----- hw/rtl/fcne_range_stage.sv -----
module fcne_range_stage (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [fcne_pkg::UPLEN_W-1:0]   upper_length,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  fcne_pkg::item_type             in_item,
   output logic                           out_valid,
   input  logic                           out_ready,
   output fcne_pkg::cand_type             out_cand
);

   logic                                 s1_valid_ff;
   logic                                 s1_valid_in;
   fcne_pkg::item_type                   s1_item_ff;
   fcne_pkg::edge_type                   edge_ff;
   fcne_pkg::edge_type                   query;
   logic                                 s1_go;
   logic signed [fcne_pkg::DIFF_W-1:0]   dx;
   logic signed [fcne_pkg::DIFF_W-1:0]   dy;
   logic signed [fcne_pkg::SQ_W-1:0]     sqx;
   logic signed [fcne_pkg::SQ_W-1:0]     sqy;
   logic [fcne_pkg::DIST_W-1:0]          sq_dist;
   logic                                 in_range;

   // Input register: take a transfer when empty or draining
   assign in_ready    = !s1_valid_ff || out_ready;
   assign s1_go       = s1_valid_ff && out_ready;
   assign s1_valid_in = (in_valid && in_ready) || (s1_valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         s1_item_ff <= in_item;
      end
   end

   // Query edge: a first item loads it, others use the stored one
   assign query = s1_item_ff.first ? s1_item_ff.query : edge_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         edge_ff <= '0;
      end else if (s1_go && s1_item_ff.first) begin
         edge_ff <= s1_item_ff.query;
      end
   end

   // Squared distance from head to the offered point
   assign dx   = fcne_pkg::DIFF_W'($signed(query.head.x))
               - fcne_pkg::DIFF_W'($signed(s1_item_ff.pt.x));
   assign dy   = fcne_pkg::DIFF_W'($signed(query.head.y))
               - fcne_pkg::DIFF_W'($signed(s1_item_ff.pt.y));
   assign sqx  = fcne_pkg::SQ_W'(dx) * fcne_pkg::SQ_W'(dx);
   assign sqy  = fcne_pkg::SQ_W'(dy) * fcne_pkg::SQ_W'(dy);
   assign sq_dist = fcne_pkg::DIST_W'($unsigned(sqx)) + fcne_pkg::DIST_W'($unsigned(sqy));
   assign in_range = fcne_pkg::CMP_W'(sq_dist) <= fcne_pkg::CMP_W'(upper_length);

   // Hand the candidate on with its turn against the query edge
   assign out_valid             = s1_valid_ff;
   assign out_cand.query        = query;
   assign out_cand.pt           = s1_item_ff.pt;
   assign out_cand.cand         = s1_item_ff.has_point && in_range;
   assign out_cand.pt_left_edge = fcne_pkg::is_left(query.tail, query.head, s1_item_ff.pt);
   assign out_cand.first        = s1_item_ff.first;
   assign out_cand.last         = s1_item_ff.last;

   // The stored edge moves only when a first item leaves this stage
   a_edge_load: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (edge_ff != $past(edge_ff)))
         |-> $past(s1_valid_ff && out_ready && s1_item_ff.first))
      else $error("query edge changed without a first item");

endmodule

// ----- hw/rtl/fcne_turn_stage.sv -----
module fcne_turn_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  succ_mode,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  fcne_pkg::cand_type    in_cand,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output fcne_pkg::result_type  rsp_result
);

   logic                  s2_valid_ff;
   logic                  s2_valid_in;
   fcne_pkg::cand_type    s2_ff;
   logic                  slot_ready;
   logic                  s2_go;
   fcne_pkg::point_type   best_ff;
   logic                  best_left_ff;
   fcne_pkg::point_type   best_cur;
   logic                  best_left_cur;
   fcne_pkg::point_type   best_new;
   logic                  best_left_new;
   logic                  pt_left_best;
   logic                  take;
   logic                  found;
   fcne_pkg::result_type  rsp_ff;
   fcne_pkg::result_type  rsp_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;

   // Stage handshake: items without a result retire at once
   assign slot_ready  = !rsp_valid_ff || rsp_ready;
   assign s2_go       = s2_valid_ff && (!s2_ff.last || slot_ready);
   assign in_ready    = !s2_valid_ff || s2_go;
   assign s2_valid_in = (in_valid && in_ready) || (s2_valid_ff && !s2_go);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         s2_ff <= in_cand;
      end
   end

   // Running best: restart at the tail on a first item
   assign best_cur      = s2_ff.first ? s2_ff.query.tail : best_ff;
   assign best_left_cur = s2_ff.first ? 1'b0 : best_left_ff;
   assign pt_left_best  = fcne_pkg::is_left(s2_ff.query.head, best_cur, s2_ff.pt);
   assign take = s2_ff.cand && (best_left_cur ? (s2_ff.pt_left_edge && pt_left_best)
                                              : (s2_ff.pt_left_edge || pt_left_best));
   assign best_new      = take ? s2_ff.pt : best_cur;
   assign best_left_new = take ? s2_ff.pt_left_edge : best_left_cur;

   always_ff @(posedge clock) begin
      if (reset) begin
         best_ff      <= '0;
         best_left_ff <= 1'b0;
      end else if (s2_go) begin
         best_ff      <= best_new;
         best_left_ff <= best_left_new;
      end
   end

   // Form the answer; an empty search in succ mode gives the zero edge
   assign found = (best_new != s2_ff.query.tail);

   always_comb begin
      rsp_in.tail  = s2_ff.query.head;
      rsp_in.head  = best_new;
      rsp_in.found = found;
      if (!found && succ_mode) begin
         rsp_in = '0;
      end
   end

   // Result register: hold until the transfer completes
   assign rsp_valid_in = (s2_go && s2_ff.last) || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_go && s2_ff.last) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_ff;

   // A last item blocked by a full result register leaves the best untouched
   a_stall_best: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && s2_ff.last && !slot_ready) |=> (best_ff == $past(best_ff)))
      else $error("best point moved while the result was blocked");

   // A waiting item is never dropped
   a_keep_item: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && !s2_go) |=> s2_valid_ff)
      else $error("stage item lost while stalled");

   // No neighbor found in succ mode means an all-zero edge
   a_zero_edge: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.found && succ_mode)
         |-> ((rsp_ff.tail == '0) && (rsp_ff.head == '0)))
      else $error("succ mode result not zero");

endmodule

// ----- hw/rtl/face_cycle_next_edge.sv -----
// Channel | Direction | Handshake          | Contents
// req     | in        | tvalid/tready      | tdata, tuser {has_point, first}, tlast
// rsp     | out       | tvalid/tready      | tdata, tuser {found}
// csr     | in        | csr_we             | csr_index, csr_wdata (no read-back)
//
// One item is taken every cycle while req_tready is high; the result of the item
// that carries last passes the input register, turn stage and result register.
// The running best point closes its loop in the turn stage, through combinational logic.
// Reset clears the stored query edge and best point to zero, upper_length to 0
// and succ_mode to 1. A stalled rsp holds its result while non-last items keep
// flowing; req_tready drops only once every stage is full.
module face_cycle_next_edge (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // tail_x, tail_y, head_x, head_y, point_x, point_y
   input  logic [fcne_pkg::REQ_DATA_W-1:0]     req_tdata,
   // has_point, first
   input  logic [fcne_pkg::REQ_USER_W-1:0]     req_tuser,
   input  logic                                req_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // next_tail_x, next_tail_y, next_head_x, next_head_y
   output logic [fcne_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // found
   output logic [0:0]                          rsp_tuser,
   input  logic                                csr_we,
   input  logic [fcne_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [fcne_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int CW = fcne_pkg::COORD_WIDTH;

   logic [fcne_pkg::UPLEN_W-1:0]  upper_length_ff;
   logic                          succ_mode_ff;
   fcne_pkg::item_type            req_item;
   fcne_pkg::cand_type            cand;
   logic                          cand_valid;
   logic                          cand_ready;
   fcne_pkg::result_type          result;

   // Register file writes
   always_ff @(posedge clock) begin
      if (reset) begin
         upper_length_ff <= '0;
         succ_mode_ff    <= 1'b1;
      end else if (csr_we) begin
         case (csr_index)
            fcne_pkg::CSR_UPPER_LENGTH: begin
               upper_length_ff <= csr_wdata[fcne_pkg::UPLEN_W-1:0];
            end
            fcne_pkg::CSR_SUCC_MODE: begin
               succ_mode_ff <= csr_wdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   // Unpack the request
   assign req_item.query.tail.x = req_tdata[0*CW +: CW];
   assign req_item.query.tail.y = req_tdata[1*CW +: CW];
   assign req_item.query.head.x = req_tdata[2*CW +: CW];
   assign req_item.query.head.y = req_tdata[3*CW +: CW];
   assign req_item.pt.x         = req_tdata[4*CW +: CW];
   assign req_item.pt.y         = req_tdata[5*CW +: CW];
   assign req_item.has_point    = req_tuser[fcne_pkg::USER_HAS_POINT];
   assign req_item.first        = req_tuser[fcne_pkg::USER_FIRST];
   assign req_item.last         = req_tlast;

   fcne_range_stage u_range (
      .clock        (clock),
      .reset        (reset),
      .upper_length (upper_length_ff),
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .in_item      (req_item),
      .out_valid    (cand_valid),
      .out_ready    (cand_ready),
      .out_cand     (cand)
   );

   fcne_turn_stage u_turn (
      .clock      (clock),
      .reset      (reset),
      .succ_mode  (succ_mode_ff),
      .in_valid   (cand_valid),
      .in_ready   (cand_ready),
      .in_cand    (cand),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_result (result)
   );

   // Pack the result
   assign rsp_tdata = fcne_pkg::RSP_DATA_W'({result.head.y, result.head.x,
                                            result.tail.y, result.tail.x});
   assign rsp_tuser = result.found;

endmodule

// ----- tb/fcne_checker.sv -----
module fcne_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   input  logic                                req_tready,
   // tail_x, tail_y, head_x, head_y, point_x, point_y
   input  logic [fcne_pkg::REQ_DATA_W-1:0]     req_tdata,
   // has_point, first
   input  logic [fcne_pkg::REQ_USER_W-1:0]     req_tuser,
   input  logic                                req_tlast,
   input  logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // next_tail_x, next_tail_y, next_head_x, next_head_y
   input  logic [fcne_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // found
   input  logic [0:0]                          rsp_tuser,
   input  logic                                csr_we,
   input  logic [fcne_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [fcne_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output int                                  pending_results,
   output int                                  mismatch_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import fcne_pkg::*;

   localparam int CW = COORD_WIDTH;

   // Walk state: stored query edge, running best neighbor, register copies
   point_type          walk_tail;
   point_type          walk_head;
   point_type          walk_best;
   logic [UPLEN_W-1:0] reach_limit;
   logic               succ_zero;

   // Next edges still owed by the block, oldest first
   result_type         next_edge_q[$];

   task automatic flag_mismatch(input string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [CW-1:0] got,
                              input logic [CW-1:0] want);
      if (got !== want)
         flag_mismatch($sformatf("%s got %0d expected %0d", name, $signed(got),
                                 $signed(want)));
   endtask

   // Strict left turn of c seen along a -> b
   function automatic bit left_turn(point_type a, point_type b, point_type c);
      longint ux;
      longint uy;
      longint vx;
      longint vy;
      ux = longint'(b.x) - longint'(a.x);
      uy = longint'(b.y) - longint'(a.y);
      vx = longint'(c.x) - longint'(a.x);
      vy = longint'(c.y) - longint'(a.y);
      return (ux * vy - uy * vx) > 0;
   endfunction

   // Fold one neighbor item into the walk; queue the next edge on a last item
   task automatic advance_face_walk(input item_type it);
      longint     dx;
      longint     dy;
      longint     dist_sq;
      longint     limit;
      bit         take;
      result_type edge_out;
      if (it.first) begin
         walk_tail = it.query.tail;
         walk_head = it.query.head;
         walk_best = it.query.tail;
      end
      if (it.has_point) begin
         dx      = longint'(walk_head.x) - longint'(it.pt.x);
         dy      = longint'(walk_head.y) - longint'(it.pt.y);
         dist_sq = dx * dx + dy * dy;
         limit   = longint'(reach_limit);
         if (dist_sq <= limit) begin
            if (left_turn(walk_tail, walk_head, walk_best))
               take = left_turn(walk_tail, walk_head, it.pt) &&
                      left_turn(walk_head, walk_best, it.pt);
            else
               take = left_turn(walk_tail, walk_head, it.pt) ||
                      left_turn(walk_head, walk_best, it.pt);
            if (take)
               walk_best = it.pt;
         end
      end
      if (it.last) begin
         if (walk_best == walk_tail && succ_zero) begin
            edge_out = '0;
         end else begin
            edge_out.tail  = walk_head;
            edge_out.head  = walk_best;
            edge_out.found = (walk_best != walk_tail);
         end
         next_edge_q.push_back(edge_out);
      end
   endtask

   always @(posedge clock) begin : monitor
      item_type   req_item;
      result_type want;
      if (reset) begin
         reach_limit = '0;
         succ_zero   = 1'b1;
         walk_tail   = '0;
         walk_head   = '0;
         walk_best   = '0;
         next_edge_q.delete();
      end else begin
         // Track register writes
         if (csr_we) begin
            case (csr_index)
               CSR_UPPER_LENGTH: reach_limit = csr_wdata;
               CSR_SUCC_MODE:    succ_zero   = csr_wdata[0];
               default: ;
            endcase
         end
         // Predict from each input transfer
         if (req_tvalid && req_tready) begin
            req_item.query.tail.x = req_tdata[0*CW +: CW];
            req_item.query.tail.y = req_tdata[1*CW +: CW];
            req_item.query.head.x = req_tdata[2*CW +: CW];
            req_item.query.head.y = req_tdata[3*CW +: CW];
            req_item.pt.x         = req_tdata[4*CW +: CW];
            req_item.pt.y         = req_tdata[5*CW +: CW];
            req_item.has_point    = req_tuser[USER_HAS_POINT];
            req_item.first        = req_tuser[USER_FIRST];
            req_item.last         = req_tlast;
            advance_face_walk(req_item);
         end
         // Compare each result transfer with the oldest next edge
         if (rsp_tvalid && rsp_tready) begin
            if (next_edge_q.size() == 0) begin
               flag_mismatch($sformatf("result with nothing expected, tdata %h found %b",
                                       rsp_tdata, rsp_tuser));
            end else begin
               want = next_edge_q.pop_front();
               check_field("next_tail_x", rsp_tdata[0*CW +: CW], want.tail.x);
               check_field("next_tail_y", rsp_tdata[1*CW +: CW], want.tail.y);
               check_field("next_head_x", rsp_tdata[2*CW +: CW], want.head.x);
               check_field("next_head_y", rsp_tdata[3*CW +: CW], want.head.y);
               check_field("found", CW'(rsp_tuser[0]), CW'(want.found));
            end
         end
      end
      pending_results <= next_edge_q.size();
   end

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import fcne_pkg::*;

   localparam logic [UPLEN_W-1:0] MAX_REACH      = 33'd8589672450;
   localparam int                 WATCHDOG_LIMIT = 2000;
   localparam int                 PHASES         = 8;
   localparam int                 PHASE_ITEMS    = 144;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   // tail_x, tail_y, head_x, head_y, point_x, point_y
   logic [REQ_DATA_W-1:0]  req_tdata;
   // has_point, first
   logic [REQ_USER_W-1:0]  req_tuser;
   logic                   req_tlast;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   // next_tail_x, next_tail_y, next_head_x, next_head_y
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   // found
   logic [0:0]             rsp_tuser;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   int pending_results;
   int mismatch_count;
   int idle_pct;
   int stall_pct;
   int items_sent;

   // Edge last loaded, so neighbors land near its head
   coord_type cur_tx;
   coord_type cur_ty;
   coord_type cur_hx;
   coord_type cur_hy;

   face_cycle_next_edge dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   fcne_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .req_tlast       (req_tlast),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .pending_results (pending_results),
      .mismatch_count  (mismatch_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Stall the result side at random
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // End the run when no transfer happens for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet = 0;
         else
            quiet++;
      end
      $display("FAILURE");
      $finish;
   end

   // Present one item after a random idle gap and hold it until the transfer
   task automatic send_item(input coord_type tx, input coord_type ty, input coord_type hx,
                            input coord_type hy, input coord_type px, input coord_type py,
                            input bit hp, input bit fst, input bit lst);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {py, px, hy, hx, ty, tx};
      req_tuser  <= {fst, hp};
      req_tlast  <= lst;
      if (fst) begin
         cur_tx = tx;
         cur_ty = ty;
         cur_hx = hx;
         cur_hy = hy;
      end
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      @(negedge clock);
      items_sent++;
   endtask

   // Wait until every next edge has come out and the pipe has settled
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_results != 0)
         @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   // Write both registers on consecutive cycles
   task automatic configure(input logic [UPLEN_W-1:0] reach, input bit succ);
      csr_we    <= 1'b1;
      csr_index <= CSR_UPPER_LENGTH;
      csr_wdata <= reach;
      @(negedge clock);
      csr_index <= CSR_SUCC_MODE;
      csr_wdata <= CSR_DATA_W'(succ);
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // Random coordinate over the whole range
   function automatic coord_type any_coord();
      return coord_type'($urandom);
   endfunction

   // Random flag
   function automatic bit any_flag();
      return 1'($urandom_range(1));
   endfunction

   // Coordinate near c, or anywhere when span is zero
   function automatic coord_type near(input coord_type c, input int span);
      coord_type r;
      if (span == 0)
         r = any_coord();
      else
         r = coord_type'(int'(c) + int'($urandom_range(2 * span)) - span);
      return r;
   endfunction

   // Neighbor of the current head; sometimes exactly the tail or the head
   task automatic pick_neighbor(input int span, output coord_type px, output coord_type py);
      int r;
      r = $urandom_range(99);
      if (r < 12) begin
         px = cur_tx;
         py = cur_ty;
      end else if (r < 17) begin
         px = cur_hx;
         py = cur_hy;
      end else begin
         px = near(cur_hx, span);
         py = near(cur_hy, span);
      end
   endtask

   task automatic send_random_query();
      int        kind;
      int        span;
      int        remaining;
      int        k;
      bit        hp;
      bit        cut;
      coord_type bx;
      coord_type by;
      coord_type tx;
      coord_type ty;
      coord_type hx;
      coord_type hy;
      coord_type px;
      coord_type py;
      kind = $urandom_range(99);
      span = ($urandom_range(3) == 0) ? 0 : $urandom_range(12, 1);
      if (kind >= 96) begin
         // noise: every field and flag random
         send_item(any_coord(), any_coord(), any_coord(), any_coord(), any_coord(),
                   any_coord(), any_flag(), any_flag(), any_flag());
      end else if (kind >= 90) begin
         // keep walking the stored edge with no first item
         remaining = $urandom_range(3, 1);
         for (k = 0; k < remaining; k++) begin
            pick_neighbor(span, px, py);
            send_item(any_coord(), any_coord(), any_coord(), any_coord(), px, py, 1'b1,
                      1'b0, k == remaining - 1);
         end
      end else begin
         // well-formed run, cut short now and then
         cut = (kind >= 84);
         bx  = any_coord();
         by  = any_coord();
         tx  = near(bx, span);
         ty  = near(by, span);
         hx  = near(bx, span);
         hy  = near(by, span);
         cur_tx = tx;
         cur_ty = ty;
         cur_hx = hx;
         cur_hy = hy;
         remaining = $urandom_range(6, 0);
         hp = (remaining > 0) && ($urandom_range(1) == 1);
         if (hp)
            remaining--;
         pick_neighbor(span, px, py);
         send_item(tx, ty, hx, hy, px, py, hp, 1'b1, (remaining == 0) && !cut);
         while (remaining > 0) begin
            pick_neighbor(span, px, py);
            hp = ($urandom_range(9) != 0);
            if (hp)
               remaining--;
            send_item(any_coord(), any_coord(), any_coord(), any_coord(), px, py, hp, 1'b0,
                      (remaining == 0) && !cut);
         end
      end
   endtask

   initial begin : stimulus
      int                 phase;
      int                 goal;
      logic [UPLEN_W-1:0] reach;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      req_tlast  = 1'b0;
      csr_we     = 1'b0;
      csr_index  = CSR_UPPER_LENGTH;
      csr_wdata  = '0;
      idle_pct   = 0;
      stall_pct  = 0;
      items_sent = 0;
      cur_tx     = '0;
      cur_ty     = '0;
      cur_hx     = '0;
      cur_hy     = '0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset settings: zero reach, zero edge on nothing found
      send_item(0, 0, 0, 0, 0, 0, 1'b0, 1'b0, 1'b1);
      send_item(0, 0, 0, 0, 5, 5, 1'b1, 1'b0, 1'b1);
      send_item(-32768, 32767, 32767, -32768, 0, 0, 1'b0, 1'b1, 1'b1);
      send_item(3, -7, -2, 4, -2, 4, 1'b1, 1'b1, 1'b1);
      drain();
      configure(MAX_REACH, 1'b0);

      // Full reach, reversed edge on nothing found; extreme coordinates
      send_item(0, 0, 10, 0, 10, 10, 1'b1, 1'b1, 1'b1);
      send_item(-32768, -32768, 32767, 32767, -32768, 32767, 1'b1, 1'b1, 1'b1);
      send_item(-32768, 32767, 32767, -32768, 32767, 32767, 1'b1, 1'b1, 1'b1);
      send_item(0, 0, 32767, 32767, -32768, -32768, 1'b1, 1'b1, 1'b1);
      send_item(7, -3, 1, 9, 7, -3, 1'b1, 1'b1, 1'b1);
      send_item(0, 0, 4, 0, 0, 0, 1'b0, 1'b1, 1'b0);
      send_item(0, 0, 0, 0, 4, 3, 1'b1, 1'b0, 1'b0);
      send_item(0, 0, 0, 0, 6, 2, 1'b1, 1'b0, 1'b0);
      send_item(0, 0, 0, 0, 2, 5, 1'b1, 1'b0, 1'b0);
      send_item(0, 0, 0, 0, 4, -3, 1'b1, 1'b0, 1'b1);
      send_item(-5, 8, 12, -1, 0, 0, 1'b0, 1'b1, 1'b1);
      drain();
      configure(33'd25, 1'b1);

      // Tight reach: boundary distance, degenerate edge, walk without first
      send_item(0, 0, 0, 0, 3, 4, 1'b1, 1'b1, 1'b1);
      send_item(0, 0, 10, 0, 10, 6, 1'b1, 1'b1, 1'b0);
      send_item(0, 0, 0, 0, 10, 5, 1'b1, 1'b0, 1'b1);
      send_item(0, 0, 0, 0, 13, 4, 1'b1, 1'b0, 1'b1);

      // Random phases, each with its own settings and idling
      for (phase = 0; phase < PHASES; phase++) begin
         drain();
         case (phase % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 69; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 69; end
            default: begin idle_pct = 35; stall_pct = 35; end
         endcase
         if (phase == 0) begin
            reach = MAX_REACH;
         end else if (phase == 1) begin
            reach = '0;
         end else begin
            case ($urandom_range(3))
               0: reach = MAX_REACH;
               1: reach = UPLEN_W'($urandom_range(300));
               2: reach = UPLEN_W'($urandom_range(20000));
               default: begin
                  reach     = UPLEN_W'($urandom);
                  reach[32] = any_flag();
                  if (reach > MAX_REACH)
                     reach = MAX_REACH;
               end
            endcase
         end
         configure(reach, 1'(phase % 2));
         goal = items_sent + PHASE_ITEMS;
         while (items_sent < goal)
            send_random_query();
      end

      drain();
      if (mismatch_count == 0 && pending_results == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

// ----- face_cycle_next_edge.f -----
hw/rtl/fcne_pkg.sv
hw/rtl/fcne_range_stage.sv
hw/rtl/fcne_turn_stage.sv
hw/rtl/face_cycle_next_edge.sv
tb/fcne_checker.sv
tb/tb_top.sv
